### rtl/psd_pkg.sv
// Shared types, register codes and scaling constants for the pressure switch debounce unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  // Widths fixed by the field definitions.
  localparam int unsigned RAW_W      = 10;
  localparam int unsigned PRESS_W    = 13;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned BOUNCE_W   = 7;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // Default width of the bleed countdown.
  localparam int unsigned BLEED_BITS_DEFAULT = 16;

  // Scaling: (raw - 80) * 25 / 8, truncating toward zero.
  localparam logic signed [RAW_W:0]   RAW_OFFSET  = 11'sd80;
  localparam logic signed [15:0]      SCALE_MUL   = 16'sd25;
  localparam int unsigned             SCALE_SHIFT = 3;
  localparam logic signed [15:0]      ROUND_BIAS  = 16'sd7;
  localparam logic signed [PRESS_W-1:0] PRESS_MAX = 13'sd2000;

  // Counter value that a forced shutdown loads; it meets any bounce count.
  localparam logic signed [CNT_W:0] FORCE_CNT = 9'sd127;

  // Register reset values.
  localparam logic [THR_W-1:0]    OFF_THR_RESET = 11'd1200;
  localparam logic [THR_W-1:0]    ON_THR_RESET  = 11'd900;
  localparam logic [BOUNCE_W-1:0] BOUNCE_RESET  = 7'd5;
  localparam logic [DUR_W-1:0]    BLEED_RESET   = 16'd2000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFF_THR = 2'd0,
    CFG_ON_THR  = 2'd1,
    CFG_BOUNCE  = 2'd2,
    CFG_BLEED   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]    off_threshold;
    logic [THR_W-1:0]    on_threshold;
    logic [BOUNCE_W-1:0] switch_samples;
    logic [DUR_W-1:0]    bleed_duration;
  } cfg_t;

  typedef struct packed {
    logic                       compressor_on;
    logic                       bleed_open;
    logic signed [PRESS_W-1:0]  pressure_tenths;
    logic                       fault;
  } result_t;

endpackage

`default_nettype wire

### rtl/psd_cfg_regs.sv
// Configuration register file: thresholds, bounce count and bleed duration.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output psd_pkg::cfg_t                        cfg_o
);
  import psd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFF_THR: cfg_d.off_threshold  = cfg_data_i[THR_W-1:0];
        CFG_ON_THR:  cfg_d.on_threshold   = cfg_data_i[THR_W-1:0];
        CFG_BOUNCE:  cfg_d.switch_samples = cfg_data_i[BOUNCE_W-1:0];
        CFG_BLEED:   cfg_d.bleed_duration = cfg_data_i[DUR_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_threshold  <= OFF_THR_RESET;
      cfg_q.on_threshold   <= ON_THR_RESET;
      cfg_q.switch_samples <= BOUNCE_RESET;
      cfg_q.bleed_duration <= BLEED_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/psd_scale.sv
// Converts a raw ADC reading to tenths of PSI: (raw - 80) * 25 / 8, truncated toward zero.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_scale (
  input  wire logic [psd_pkg::RAW_W-1:0]          raw_i,
  output logic signed [psd_pkg::PRESS_W-1:0]      pressure_o
);
  import psd_pkg::*;

  logic signed [RAW_W:0] diff;
  logic signed [15:0]    prod;
  logic signed [15:0]    biased;
  logic signed [15:0]    shifted;

  // A negative product gets the divisor minus one added before the
  // arithmetic shift, so the shift rounds toward zero.
  assign diff    = $signed({1'b0, raw_i}) - RAW_OFFSET;
  assign prod    = 16'(diff) * SCALE_MUL;
  assign biased  = prod + (prod[15] ? ROUND_BIAS : 16'sd0);
  assign shifted = biased >>> SCALE_SHIFT;
  assign pressure_o = shifted[PRESS_W-1:0];

endmodule

`default_nettype wire

### rtl/psd_ctrl.sv
// Controller state: debounce counter, compressor drive, bleed countdown and last sample.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_ctrl #(
  parameter int unsigned BLEED_COUNTER_BITS = psd_pkg::BLEED_BITS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic                               op_i,
  input  wire logic signed [psd_pkg::PRESS_W-1:0] pressure_i,
  input  wire logic                               quiet_i,
  input  wire psd_pkg::cfg_t                      cfg_i,
  output psd_pkg::result_t                        res_o
);
  import psd_pkg::*;

  logic                          running_q, running_d;
  logic signed [CNT_W-1:0]       cnt_q, cnt_d;
  logic [BLEED_COUNTER_BITS-1:0] bleed_q, bleed_d;
  logic signed [PRESS_W-1:0]     last_press_q, last_press_d;
  logic                          last_fault_q, last_fault_d;

  logic signed [CNT_W:0]         cnt_x;
  logic signed [CNT_W:0]         cnt_mid;
  logic signed [CNT_W:0]         bc_pos;
  logic signed [CNT_W:0]         bc_neg;
  logic signed [PRESS_W-1:0]     off_thr;
  logic signed [PRESS_W-1:0]     on_thr;
  logic                          bad;
  logic [BLEED_COUNTER_BITS+DUR_W-1:0] dur_ext;
  logic [BLEED_COUNTER_BITS-1:0] bleed_load;

  assign cnt_x   = {cnt_q[CNT_W-1], cnt_q};
  assign bc_pos  = $signed({2'b00, cfg_i.switch_samples});
  assign bc_neg  = -bc_pos;
  assign off_thr = $signed({2'b00, cfg_i.off_threshold});
  assign on_thr  = $signed({2'b00, cfg_i.on_threshold});
  assign bad     = (pressure_i < 0) || (pressure_i > PRESS_MAX) || quiet_i;

  // The duration is truncated or zero-extended to the countdown width.
  assign dur_ext    = {{BLEED_COUNTER_BITS{1'b0}}, cfg_i.bleed_duration};
  assign bleed_load = dur_ext[BLEED_COUNTER_BITS-1:0];

  always_comb begin
    running_d    = running_q;
    cnt_d        = cnt_q;
    bleed_d      = bleed_q;
    last_press_d = last_press_q;
    last_fault_d = last_fault_q;
    cnt_mid      = cnt_x;

    if (valid_i) begin
      if (op_e'(op_i) == OP_TICK) begin
        if (bleed_q != '0) begin
          bleed_d = bleed_q - 1'b1;
        end
      end else begin
        priority if (bad) begin
          cnt_mid = FORCE_CNT;
        end else if ((pressure_i > off_thr) && (cnt_x < bc_pos) && running_q) begin
          cnt_mid = cnt_x + 9'sd1;
        end else if ((pressure_i < on_thr) && (cnt_x > bc_neg) && !running_q) begin
          cnt_mid = cnt_x - 9'sd1;
        end else begin
          cnt_mid = '0;
        end

        priority if (cnt_mid >= bc_pos) begin
          cnt_d     = '0;
          running_d = 1'b0;
          if (running_q) begin
            bleed_d = bleed_load;
          end
        end else if (cnt_mid <= bc_neg) begin
          cnt_d     = '0;
          running_d = 1'b1;
        end else begin
          cnt_d = cnt_mid[CNT_W-1:0];
        end

        last_press_d = pressure_i;
        last_fault_d = bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      cnt_q        <= '0;
      bleed_q      <= '0;
      last_press_q <= '0;
      last_fault_q <= 1'b0;
    end else begin
      running_q    <= running_d;
      cnt_q        <= cnt_d;
      bleed_q      <= bleed_d;
      last_press_q <= last_press_d;
      last_fault_q <= last_fault_d;
    end
  end

  // Result of the item being processed, taken from the updated state.
  assign res_o.compressor_on   = running_d;
  assign res_o.bleed_open      = (bleed_d != '0);
  assign res_o.pressure_tenths = last_press_d;
  assign res_o.fault           = last_fault_d;

endmodule

`default_nettype wire

### rtl/pressure_switch_debounce_unit.sv
// Pressure switch debounce unit, top level.
// An accepted word passes through the input register and then the result register, which drives the output.
// Throughput: one word per cycle unless the result stream stalls; the state update in psd_ctrl sets the rate.
// The input register frees up whenever the result register is empty or being drained.
// Reset (rst_ni low, asynchronous) turns the compressor off, closes the bleed valve,
// clears the debounce counter and last sample, empties both stages, and loads default registers.
`timescale 1ns / 1ps
`default_nettype none

module pressure_switch_debounce_unit #(
  parameter int unsigned BLEED_COUNTER_BITS = psd_pkg::BLEED_BITS_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, low bit up: raw_sample[9:0], quiet[10], zero padding[15:11].
  input  wire logic [psd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: operation (0 = pressure sample, 1 = millisecond tick).
  input  wire logic                            s_axis_tuser,

  // Result stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata, low bit up: compressor_on[0], bleed_open[1], pressure_tenths[14:2], fault[15].
  output logic [psd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,

  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import psd_pkg::*;

  // Input register: holds one accepted word until the controller consumes it.
  logic               in_valid_q, in_valid_d;
  logic               in_op_q, in_op_d;
  logic [RAW_W-1:0]   in_raw_q, in_raw_d;
  logic               in_quiet_q, in_quiet_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  result_t            out_res_q, out_res_d;

  logic               advance;
  logic               s_fire;
  cfg_t               cfg;
  logic signed [PRESS_W-1:0] pressure;
  result_t            res;

  // The word in the input register moves on whenever the result register
  // is empty or its word is taken in this same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  psd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  psd_scale u_scale (
    .raw_i     (in_raw_q),
    .pressure_o(pressure)
  );

  psd_ctrl #(
    .BLEED_COUNTER_BITS(BLEED_COUNTER_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (advance),
    .op_i      (in_op_q),
    .pressure_i(pressure),
    .quiet_i   (in_quiet_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_op_d    = in_op_q;
    in_raw_d   = in_raw_q;
    in_quiet_d = in_quiet_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
      in_op_d    = s_axis_tuser;
      in_raw_d   = s_axis_tdata[RAW_W-1:0];
      in_quiet_d = s_axis_tdata[RAW_W];
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_op_q    <= in_op_d;
    in_raw_q   <= in_raw_d;
    in_quiet_q <= in_quiet_d;
    out_res_q  <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.fault, out_res_q.pressure_tenths,
                          out_res_q.bleed_open, out_res_q.compressor_on};

`ifndef SYNTHESIS
  // A word handed to the result register must show up as a valid output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result word lost after leaving the input register");

  // A fault always forces the compressor off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OUT_DATA_W-1]) |-> !m_axis_tdata[0])
    else $error("compressor running while a fault is reported");

  // A result word that is not taken stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");
`endif

endmodule

`default_nettype wire
